FILE: hw/rtl/dect_standard_cipher_keystream_top_defines.svh
// assertion macros for the dsc keystream block
`ifndef DECT_STANDARD_CIPHER_KEYSTREAM_TOP_DEFINES_SVH
`define DECT_STANDARD_CIPHER_KEYSTREAM_TOP_DEFINES_SVH

// same-cycle implication
`define DSC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsc assertion failed");

// next-cycle implication
`define DSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsc assertion failed");

`endif

FILE: hw/rtl/dsc_pkg.sv
// shared types, constants and functions of the dsc keystream block
package dsc_pkg;

  localparam int DSC_MAX_BYTES = 64;
  localparam int DSC_LOAD_STEPS = 128;
  localparam int DSC_PRE_STEPS = 40;
  localparam int DSC_FIX_STEP = 11;

  localparam int IV_W = 40;
  localparam int COUNT_W = 7;
  localparam int KEY_W = 64;
  localparam int BYTE_W = 8;

  localparam int LEN_ONE = 17;
  localparam int LEN_TWO = 19;
  localparam int LEN_THREE = 21;
  localparam int LEN_FOUR = 23;

  localparam logic [22:0] TAPS_ONE = 23'(65536 | 32);
  localparam logic [22:0] TAPS_TWO = 23'(262144 | 4096 | 8 | 4);
  localparam logic [22:0] TAPS_THREE = 23'(1048576 | 2);
  localparam logic [22:0] TAPS_FOUR = 23'(256 | 4194304);

  localparam int CTL_ONE = 8;
  localparam int CTL_TWO = 9;
  localparam int CTL_THREE = 10;

  typedef struct packed {
    logic start;
    logic load;
    logic step;
    logic fix;
    logic collect;
    logic emit;
    logic last;
  } dsc_cmd_t;

  typedef struct packed {
    logic out_full;
  } dsc_sts_t;

  // one galois shift, narrower registers zero-extended
  function automatic logic [22:0] dsc_shift(input logic [22:0] r, input logic [22:0] taps);
    dsc_shift = (r >> 1) ^ (r[0] ? taps : 23'd0);
  endfunction

  function automatic logic dsc_mix(input logic c, input logic [1:0] a, input logic [1:0] b,
                                   input logic [1:0] d);
    dsc_mix = (a[1] & a[0] & c) ^ (b[0] & a[1] & a[0]) ^ (b[1] & a[0] & c) ^
              (b[1] & b[0] & a[0]) ^ (d[0] & a[0] & c) ^ (d[0] & b[0] & a[0]) ^
              (a[1] & c) ^ (a[1] & a[0]) ^ (b[0] & a[1]) ^ (d[0] & c) ^
              (d[1] & c) ^ (d[1] & a[0]) ^ b[1] ^ d[1];
  endfunction

endpackage

FILE: hw/rtl/dsc_in_if.sv
// request channel interface
interface dsc_in_if import dsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IV_W-1:0]    init_vector;
  logic [COUNT_W-1:0] byte_count;

  modport source (output valid, output init_vector, output byte_count, input ready);
  modport sink (input valid, input init_vector, input byte_count, output ready);
endinterface

FILE: hw/rtl/dsc_out_if.sv
// keystream byte channel interface
interface dsc_out_if import dsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] key_byte;
  logic              last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/dect_standard_cipher_keystream_top.sv
// top level of the dsc keystream generator
//
//   channel  dir  payload                         accept
//   in_i     in   init_vector[39:0] byte_count[6:0] valid & ready
//   out_o    out  key_byte[7:0] last_byte        valid & ready
//   cfg      in   cfg_wdata_i[63:0] cipher key    cfg_we_i
//
// a request runs a start, the key and iv load, the pre-cipher steps and the output steps
// the four lfsrs advance one cipher step per cycle in the pre-cipher and output phases, unless output stalls
// a zero byte count is taken and dropped, no bytes follow
// a byte waits in the output register; a second finished byte stalls the steps
// reset is asynchronous, active low, and returns the sequencer to idle
module dect_standard_cipher_keystream_top import dsc_pkg::*; #(
  parameter int MAX_BYTES = DSC_MAX_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [KEY_W-1:0] cfg_wdata_i,
  dsc_in_if.sink           in_i,
  dsc_out_if.source        out_o
);

  `include "dect_standard_cipher_keystream_top_defines.svh"

  dsc_cmd_t cmd;
  dsc_sts_t sts;

  dsc_ctrl #(
    .MAX_BYTES(MAX_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .byte_count_i(in_i.byte_count),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .init_vector_i(in_i.init_vector),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .key_byte_o   (out_o.key_byte),
    .last_byte_o  (out_o.last_byte)
  );

  `DSC_ASSERT_NEXT(a_start_then_load, cmd.start, cmd.load)
  `DSC_ASSERT_IMPLY(a_no_overwrite, cmd.emit, !sts.out_full)
  `DSC_ASSERT_NEXT(a_busy_after_start, cmd.start, !in_i.ready)
  `DSC_ASSERT_IMPLY(a_emit_on_step, cmd.emit, cmd.step && cmd.collect)

endmodule

FILE: hw/rtl/dsc_ctrl.sv
// sequencer for load, pre-cipher and output phases
module dsc_ctrl import dsc_pkg::*; #(
  parameter int MAX_BYTES = DSC_MAX_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [COUNT_W-1:0] byte_count_i,
  output logic               in_ready_o,
  input  dsc_sts_t           sts_i,
  output dsc_cmd_t           cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_PRE  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [2:0]         bit_q, bit_d;
  logic [COUNT_W-1:0] left_q, left_d;
  logic [COUNT_W-1:0] sat_count;

  assign sat_count = (byte_count_i > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : byte_count_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    left_d  = left_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (byte_count_i != '0)) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          left_d      = sat_count;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = cnt_q + 7'd1;
        if (cnt_q == 7'(DSC_LOAD_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.step = 1'b1;
        cmd_o.fix  = (cnt_q == 7'(DSC_FIX_STEP));
        cnt_d      = cnt_q + 7'd1;
        if (cnt_q == 7'(DSC_PRE_STEPS - 1)) begin
          cnt_d   = '0;
          bit_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!((bit_q == 3'd7) && sts_i.out_full)) begin
          cmd_o.step    = 1'b1;
          cmd_o.collect = 1'b1;
          bit_d         = bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = (left_q == COUNT_W'(1));
            left_d     = left_q - COUNT_W'(1);
            if (left_q == COUNT_W'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: hw/rtl/dsc_datapath.sv
// lfsrs, combiner, key register and output register
module dsc_datapath import dsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [KEY_W-1:0]  cfg_wdata_i,
  input  logic [IV_W-1:0]   init_vector_i,
  input  dsc_cmd_t          cmd_i,
  output dsc_sts_t          sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] key_byte_o,
  output logic              last_byte_o
);

  localparam int LOAD_W = DSC_LOAD_STEPS;

  logic [KEY_W-1:0]     key_q;
  logic [LOAD_W-1:0]    load_q, load_d;
  logic [LEN_ONE-1:0]   r1_q, r1_d;
  logic [LEN_TWO-1:0]   r2_q, r2_d;
  logic [LEN_THREE-1:0] r3_q, r3_d;
  logic [LEN_FOUR-1:0]  r4_q, r4_d;
  logic                 c_q, c_d;
  logic [BYTE_W-1:0]    acc_q, acc_d;
  logic                 ov_q, ov_d;
  logic [BYTE_W-1:0]    ob_q;
  logic                 ol_q;

  logic [LEN_ONE-1:0]   n1;
  logic [LEN_TWO-1:0]   n2;
  logic [LEN_THREE-1:0] n3;
  logic [LEN_FOUR-1:0]  n4;
  logic                 ck1, ck2, ck3, lbit;

  assign sts_o.out_full = ov_q && !out_ready_i;
  assign out_valid_o    = ov_q;
  assign key_byte_o     = ob_q;
  assign last_byte_o    = ol_q;
  assign lbit           = load_q[0];

  always_comb begin
    ck1 = r2_q[CTL_TWO] ^ r3_q[CTL_THREE] ^ r4_q[0];
    ck2 = r1_q[CTL_ONE] ^ r3_q[CTL_THREE] ^ r4_q[1];
    ck3 = r1_q[CTL_ONE] ^ r2_q[CTL_TWO] ^ r4_q[2];
    n1 = ck1 ? LEN_ONE'(dsc_shift(23'(r1_q), TAPS_ONE)) : r1_q;
    n2 = ck2 ? LEN_TWO'(dsc_shift(23'(r2_q), TAPS_TWO)) : r2_q;
    n3 = ck3 ? LEN_THREE'(dsc_shift(23'(r3_q), TAPS_THREE)) : r3_q;
    n4 = r4_q;
    if (cmd_i.fix) begin
      if (r1_q == '0) n1[LEN_ONE-1] = ~n1[LEN_ONE-1];
      if (r2_q == '0) n2[LEN_TWO-1] = ~n2[LEN_TWO-1];
      if (r3_q == '0) n3[LEN_THREE-1] = ~n3[LEN_THREE-1];
      if (r4_q == '0) n4[LEN_FOUR-1] = ~n4[LEN_FOUR-1];
    end

    load_d = load_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    r3_d   = r3_q;
    r4_d   = r4_q;
    c_d    = c_q;
    acc_d  = acc_q;
    if (cmd_i.start) begin
      load_d = {key_q, 24'd0, init_vector_i};
      r1_d   = '0;
      r2_d   = '0;
      r3_d   = '0;
      r4_d   = '0;
      c_d    = 1'b0;
      acc_d  = '0;
    end else if (cmd_i.load) begin
      load_d = load_q >> 1;
      r1_d = LEN_ONE'(dsc_shift(23'(r1_q), TAPS_ONE)) ^ {lbit, {(LEN_ONE-1){1'b0}}};
      r2_d = LEN_TWO'(dsc_shift(23'(r2_q), TAPS_TWO)) ^ {lbit, {(LEN_TWO-1){1'b0}}};
      r3_d = LEN_THREE'(dsc_shift(23'(r3_q), TAPS_THREE)) ^ {lbit, {(LEN_THREE-1){1'b0}}};
      r4_d = LEN_FOUR'(dsc_shift(23'(r4_q), TAPS_FOUR)) ^ {lbit, {(LEN_FOUR-1){1'b0}}};
    end else if (cmd_i.step) begin
      c_d  = dsc_mix(c_q, r1_q[1:0], r2_q[1:0], r3_q[1:0]);
      r1_d = LEN_ONE'(dsc_shift(dsc_shift(23'(n1), TAPS_ONE), TAPS_ONE));
      r2_d = LEN_TWO'(dsc_shift(dsc_shift(23'(n2), TAPS_TWO), TAPS_TWO));
      r3_d = LEN_THREE'(dsc_shift(dsc_shift(23'(n3), TAPS_THREE), TAPS_THREE));
      r4_d = LEN_FOUR'(dsc_shift(dsc_shift(dsc_shift(23'(n4), TAPS_FOUR), TAPS_FOUR),
                                 TAPS_FOUR));
      if (cmd_i.collect) begin
        acc_d = {acc_q[BYTE_W-2:0], c_d};
      end
    end

    ov_d = ov_q && !out_ready_i;
    if (cmd_i.emit) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q <= load_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    r3_q   <= r3_d;
    r4_q   <= r4_d;
    c_q    <= c_d;
    acc_q  <= acc_d;
    if (cmd_i.emit) begin
      ob_q <= acc_d;
      ol_q <= cmd_i.last;
    end
  end

endmodule
